FILE: design/wast_pkg.sv
`default_nettype none

package wast_pkg;

  // Position and count fields of the probe are wide enough for tables of up to 127 entries.
  localparam int IDX_W = 7;

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_DELETE     = 3'd1,
    OP_SET_ENABLE = 3'd2,
    OP_TICK       = 3'd3,
    OP_READ       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ADD,
    ACT_DELETE,
    ACT_SET_ENABLE,
    ACT_TICK,
    ACT_READ
  } act_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [6:0] weekdays;
    logic       enable;
    logic       fired_today;
  } entry_t;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic             valid;
    act_t             act;
    status_t          status;
    logic             clear_fired;
    logic             enable;
    logic [4:0]       hour;
    logic [5:0]       minute;
    logic [6:0]       weekdays;
    logic [2:0]       now_weekday;
    logic [4:0]       now_hour;
    logic [5:0]       now_minute;
    logic [IDX_W-1:0] index;
    logic [IDX_W-1:0] count;
    logic             hit;
    logic [IDX_W-1:0] hit_index;
    entry_t           rd;
  } probe_t;

endpackage

`default_nettype wire

FILE: design/wast_cell.sv
`default_nettype none

module wast_cell #(
  parameter int CELL_INDEX = 0
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wast_pkg::probe_t    probe_in,
  input  wast_pkg::entry_t    next_entry,
  output wast_pkg::probe_t    probe_out,
  output wast_pkg::entry_t    entry_out
);

  localparam logic [wast_pkg::IDX_W-1:0] MY_POS = wast_pkg::IDX_W'(CELL_INDEX);

  wast_pkg::entry_t entry;
  wast_pkg::entry_t entry_next;
  wast_pkg::probe_t probe_next;

  logic here;
  logic held;
  logic key_match;
  logic time_match;
  logic fired_now;

  assign here = (probe_in.index == MY_POS);
  assign held = (MY_POS < probe_in.count);
  assign key_match = (entry.hour == probe_in.hour) && (entry.minute == probe_in.minute) &&
                     (entry.weekdays == probe_in.weekdays);
  assign fired_now = probe_in.clear_fired ? 1'b0 : entry.fired_today;
  // A weekday code of seven selects the zero above the mask and never matches.
  assign time_match = entry.enable && !fired_now &&
                      (({1'b0, entry.weekdays} >> probe_in.now_weekday) & 8'd1) != 8'd0 &&
                      (entry.hour == probe_in.now_hour) &&
                      (({1'b0, entry.minute} == {1'b0, probe_in.now_minute}) ||
                       (({1'b0, entry.minute} + 7'd1) == {1'b0, probe_in.now_minute}));

  always_comb begin
    probe_next = probe_in;
    entry_next = entry;
    if (probe_in.valid) begin
      unique case (probe_in.act)
        wast_pkg::ACT_ADD: begin
          if (held && key_match) begin
            probe_next.hit = 1'b1;
          end else if (here && !probe_in.hit) begin
            entry_next.hour        = probe_in.hour;
            entry_next.minute      = probe_in.minute;
            entry_next.weekdays    = probe_in.weekdays;
            entry_next.enable      = probe_in.enable;
            entry_next.fired_today = 1'b0;
          end
        end
        wast_pkg::ACT_DELETE: begin
          // The neighbour above has not yet seen the probe, so it still holds its old entry.
          if (MY_POS >= probe_in.index) begin
            entry_next = next_entry;
          end
        end
        wast_pkg::ACT_SET_ENABLE: begin
          if (here) begin
            entry_next.enable      = probe_in.enable;
            entry_next.fired_today = 1'b0;
          end
        end
        wast_pkg::ACT_TICK: begin
          if (held) begin
            entry_next.fired_today = fired_now;
            if (!probe_in.hit && time_match) begin
              entry_next.fired_today = 1'b1;
              probe_next.hit         = 1'b1;
              probe_next.hit_index   = MY_POS;
            end
          end
        end
        wast_pkg::ACT_READ: begin
          if (here) begin
            probe_next.rd = entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out <= '0;
    end else begin
      probe_out <= probe_next;
    end
  end

  assign entry_out = entry;

endmodule

`default_nettype wire

FILE: design/weekly_alarm_schedule_table_core.sv
// The input beat is registered into the probe head, walks the cell row, is captured as the
// result and is then written to the output register. A new input beat is taken only once
// the previous result has been handed to the output register.
// A result waiting on the output does not block the next input beat.
// Reset (rst, synchronous, active high) empties the table and forgets the last weekday seen;
// the entry storage itself is not cleared and is never visible beyond the held count.
`default_nettype none

module weekly_alarm_schedule_table_core #(
  parameter int MAX_ENTRIES = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata from bit 0: entry_hour, entry_minute, entry_weekdays, entry_enable, entry_index,
  // time_valid, now_weekday, now_hour, now_minute, zero fill
  input  wire  [39:0] s_axis_tdata,
  // tuser: opcode
  input  wire  [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // tdata from bit 0: status, fired, fired_index, entry_count, read_hour, read_minute,
  // read_weekdays, read_enable, read_fired_today
  output logic [31:0] m_axis_tdata
);

  // The table is a row of cells, one entry each. Every operation sends a probe into cell 0;
  // it moves one cell per cycle, and each cell acts on its own entry as the probe passes.
  // Because the probe carries the first-hit flag, the earliest matching cell wins, which
  // gives both the duplicate check of an add and the single firing of a tick. A delete lets
  // each cell at or above the index copy its upper neighbour just before the probe reaches
  // that neighbour, so the gap closes in one pass.

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t state;

  logic [CW-1:0] count;
  logic [2:0]    last_weekday;

  wast_pkg::probe_t probe_head;
  wast_pkg::probe_t start_probe;
  wast_pkg::probe_t result;
  wast_pkg::probe_t probe_chain [MAX_ENTRIES];
  wast_pkg::entry_t entries     [MAX_ENTRIES];
  wast_pkg::probe_t probe_last;

  logic                         accept;
  logic [wast_pkg::IDX_W-1:0]   index_ext;
  logic [wast_pkg::IDX_W-1:0]   count_ext;
  logic                         table_full;
  logic                         out_of_range;
  logic                         tick_valid;
  logic [31:0]                  out_data;

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign probe_last    = probe_chain[MAX_ENTRIES-1];

  assign index_ext    = wast_pkg::IDX_W'(s_axis_tdata[22:19]);
  assign count_ext    = wast_pkg::IDX_W'(count);
  assign table_full   = (count >= CW'(MAX_ENTRIES));
  assign out_of_range = (index_ext >= count_ext);
  assign tick_valid   = s_axis_tdata[23];

  // Decode the beat into a probe; rejected items travel as a probe that touches nothing.
  always_comb begin
    start_probe             = '0;
    start_probe.valid       = 1'b1;
    start_probe.act         = wast_pkg::ACT_NONE;
    start_probe.status      = wast_pkg::ST_OK;
    start_probe.hour        = s_axis_tdata[4:0];
    start_probe.minute      = s_axis_tdata[10:5];
    start_probe.weekdays    = s_axis_tdata[17:11];
    start_probe.enable      = s_axis_tdata[18];
    start_probe.index       = index_ext;
    start_probe.now_weekday = s_axis_tdata[26:24];
    start_probe.now_hour    = s_axis_tdata[31:27];
    start_probe.now_minute  = s_axis_tdata[37:32];
    start_probe.count       = count_ext;
    unique case (wast_pkg::opcode_t'(s_axis_tuser))
      wast_pkg::OP_ADD: begin
        // A new entry always lands on the first free position.
        start_probe.index = count_ext;
        if (table_full) begin
          start_probe.status = wast_pkg::ST_FULL;
        end else begin
          start_probe.act = wast_pkg::ACT_ADD;
        end
      end
      wast_pkg::OP_DELETE: begin
        if (out_of_range) begin
          start_probe.status = wast_pkg::ST_RANGE;
        end else begin
          start_probe.act = wast_pkg::ACT_DELETE;
        end
      end
      wast_pkg::OP_SET_ENABLE: begin
        if (out_of_range) begin
          start_probe.status = wast_pkg::ST_RANGE;
        end else begin
          start_probe.act = wast_pkg::ACT_SET_ENABLE;
        end
      end
      wast_pkg::OP_TICK: begin
        if (tick_valid) begin
          start_probe.act         = wast_pkg::ACT_TICK;
          start_probe.clear_fired = (s_axis_tdata[26:24] != last_weekday);
        end
      end
      wast_pkg::OP_READ: begin
        if (out_of_range) begin
          start_probe.status = wast_pkg::ST_RANGE;
        end else begin
          start_probe.act = wast_pkg::ACT_READ;
        end
      end
      default: begin
      end
    endcase
  end

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    wast_pkg::probe_t cell_probe_in;
    wast_pkg::entry_t cell_next_entry;
    if (k == 0) begin : g_first
      assign cell_probe_in = probe_head;
    end else begin : g_rest
      assign cell_probe_in = probe_chain[k-1];
    end
    // The top cell's copy on delete lands beyond the held count, so its own entry will do.
    if (k == MAX_ENTRIES - 1) begin : g_top
      assign cell_next_entry = entries[k];
    end else begin : g_inner
      assign cell_next_entry = entries[k+1];
    end
    wast_cell #(
      .CELL_INDEX(k)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .probe_in  (cell_probe_in),
      .next_entry(cell_next_entry),
      .probe_out (probe_chain[k]),
      .entry_out (entries[k])
    );
  end

  // Result beat, built from the probe that left the last cell and the updated count.
  always_comb begin
    wast_pkg::status_t st;
    logic              fired;
    wast_pkg::entry_t  rd;
    st    = result.status;
    fired = (result.act == wast_pkg::ACT_TICK) && result.hit;
    rd    = (result.act == wast_pkg::ACT_READ) ? result.rd : '0;
    if ((result.act == wast_pkg::ACT_ADD) && result.hit) begin
      st = wast_pkg::ST_DUPLICATE;
    end
    out_data = {rd.fired_today, rd.enable, rd.weekdays, rd.minute, rd.hour, 5'(count),
                fired ? result.hit_index[3:0] : 4'd0, fired, st};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      count            <= '0;
      last_weekday     <= 3'd7;
      probe_head.valid <= 1'b0;
      m_axis_tvalid    <= 1'b0;
    end else begin
      // In the done state the output register is refilled below instead.
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            probe_head <= start_probe;
            state      <= S_RUN;
            if (start_probe.act == wast_pkg::ACT_TICK) begin
              last_weekday <= start_probe.now_weekday;
            end
          end
        end
        S_RUN: begin
          // The probe has entered the first cell; the head stays empty until the next beat.
          probe_head.valid <= 1'b0;
          if (probe_last.valid) begin
            result <= probe_last;
            state  <= S_DONE;
            if ((probe_last.act == wast_pkg::ACT_ADD) && !probe_last.hit) begin
              count <= count + CW'(1);
            end else if (probe_last.act == wast_pkg::ACT_DELETE) begin
              count <= count - CW'(1);
            end
          end
        end
        S_DONE: begin
          // Wait for the output register to be free before handing the result over.
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= out_data;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The held count never exceeds the size of the row.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MAX_ENTRIES))
    else $error("entry count beyond table size");

  // A probe can only leave the row while an operation is running.
  a_probe_in_run: assert property (@(posedge clk) disable iff (rst)
    probe_last.valid |-> state == S_RUN)
    else $error("probe left the row outside a run");

  // Every accepted beat launches a probe into the first cell.
  a_launch: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_RUN) && probe_head.valid)
    else $error("accepted beat did not launch a probe");

  // A fired alarm always comes with an ok status.
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == wast_pkg::ST_OK)
    else $error("fired result with non-ok status");

endmodule

`default_nettype wire
